// File: rtl/llhs_pkg.sv
// Shared types, constants and codes for the log-linear histogram statistics unit.
// Used by llhs_ctrl, llhs_dp and log_linear_histogram_stats_unit; depends on nothing.
`default_nettype none

package llhs_pkg;

  localparam int MAX_LEVELS = 32;
  localparam int MAX_BINS   = 16;
  localparam int DEPTH      = MAX_LEVELS * MAX_BINS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int K_W        = $clog2(MAX_LEVELS);
  localparam int BI_W       = $clog2(MAX_BINS);

  localparam int LVL_FW = 5;
  localparam int BIN_FW = 4;
  localparam int CFG_W  = 5;

  localparam logic [1:0] FUNC_REC   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BEYOND = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  localparam logic CFG_RANGES = 1'b0;
  localparam logic CFG_BASE   = 1'b1;

  localparam logic [CFG_W-1:0] RANGES_RST = 5'd16;
  localparam logic [CFG_W-1:0] BASE_RST   = 5'd2;

  typedef struct packed {
    logic load;
    logic lvl_step;
    logic geo;
    logic diff;
    logic bin_step;
    logic mem_rd;
    logic wb;
    logic clr_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_func;
    logic       rd_oob;
    logic       lvl_hit;
    logic       lvl_miss;
    logic       bin_done;
    logic       clr_last;
    logic       out_busy;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/llhs_ctrl.sv
// Sequencer of the log-linear histogram statistics unit.
// Drives llhs_dp through llhs_pkg::cmd_t and reacts to llhs_pkg::stat_t.
`default_nettype none

module llhs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire llhs_pkg::stat_t st,
  output llhs_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_LVL  = 4'd3;
  localparam logic [3:0] S_GEO  = 4'd4;
  localparam logic [3:0] S_DIFF = 4'd5;
  localparam logic [3:0] S_BIN  = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid & in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          cmd.load = 1'b1;
          priority if (st.in_func == llhs_pkg::FUNC_REC) begin
            state_nxt = S_LVL;
          end else if (st.in_func == llhs_pkg::FUNC_READ) begin
            state_nxt = st.rd_oob ? S_FIN : S_LVL;
          end else if (st.in_func == llhs_pkg::FUNC_CLEAR) begin
            state_nxt = S_CLR;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_nxt = S_FIN;
      end
      S_LVL: begin
        cmd.lvl_step = 1'b1;
        if (st.lvl_hit) state_nxt = S_GEO;
        else if (st.lvl_miss) state_nxt = S_FIN;
      end
      S_GEO: begin
        cmd.geo   = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_BIN;
      end
      S_BIN: begin
        cmd.bin_step = 1'b1;
        if (st.bin_done) state_nxt = S_RD;
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_WB;
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/llhs_dp.sv
// Datapath of the log-linear histogram statistics unit: configuration, level search,
// bin geometry, bin memory, running statistics and output register. Uses llhs_pkg.
`default_nettype none

module llhs_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_addr,
  input  wire logic [llhs_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic [1:0]                     in_func,
  input  wire logic [63:0]                    in_value,
  input  wire logic [llhs_pkg::LVL_FW-1:0]    in_level,
  input  wire logic [llhs_pkg::BIN_FW-1:0]    in_bin,
  input  wire logic                           out_tready,
  output logic                                out_tvalid,
  output logic [1:0]                          out_status,
  output logic [llhs_pkg::LVL_FW-1:0]         out_level,
  output logic [llhs_pkg::BIN_FW-1:0]         out_bin,
  output logic [63:0]                         out_bin_sum,
  output logic [31:0]                         out_bin_count,
  output logic [63:0]                         out_bin_begin,
  output logic [63:0]                         out_count,
  output logic [63:0]                         out_total,
  output logic [63:0]                         out_min,
  output logic [63:0]                         out_max,
  input  wire llhs_pkg::cmd_t                 cmd,
  output llhs_pkg::stat_t                     st
);

  logic [llhs_pkg::CFG_W-1:0] ranges_r, base_r;
  logic [4:0]  r_eff, b_eff;

  logic [1:0]  func_r;
  logic [63:0] v_r;
  logic [llhs_pkg::LVL_FW-1:0] rlv_r;
  logic [llhs_pkg::BIN_FW-1:0] rbi_r;

  logic [llhs_pkg::K_W-1:0]  k_r;
  logic [llhs_pkg::BI_W-1:0] bi_r;
  logic [63:0] p_r, prev_r;
  logic        pov_r, prevov_r;
  logic [63:0] begin_r, width_r, n_r;
  logic        wov_r;
  logic [68:0] off_r;

  logic [63:0] cnt_r, tot_r, min_r, max_r;

  logic [1:0]  st_status_r;
  logic [llhs_pkg::LVL_FW-1:0] st_lv_r;
  logic [llhs_pkg::BIN_FW-1:0] st_bi_r;
  logic [63:0] st_sum_r, st_beg_r;
  logic [31:0] st_cnt_r;

  logic [llhs_pkg::ADDR_W-1:0] clr_idx_r, addr;
  logic [95:0] mem [llhs_pkg::DEPTH];
  logic [95:0] rd_r;

  logic        out_valid_r;
  logic [1:0]  o_status_r;
  logic [llhs_pkg::LVL_FW-1:0] o_lv_r;
  logic [llhs_pkg::BIN_FW-1:0] o_bi_r;
  logic [63:0] o_sum_r, o_beg_r, o_cnt_r, o_tot_r, o_min_r, o_max_r;
  logic [31:0] o_bcnt_r;

  logic [68:0] lim_prod, pb_prod, bprod, wprod, nxt;
  logic        lim_ov, pb_ov, hit_rec, is_rec, bov, wovf;
  logic [63:0] new_sum, off_sat, upd_v;
  logic [31:0] new_cnt;
  logic [64:0] beg_sum;

  always_comb begin
    r_eff = ranges_r;
    if (ranges_r == '0) r_eff = 5'd1;
    else if (ranges_r > 5'(llhs_pkg::MAX_BINS)) r_eff = 5'(llhs_pkg::MAX_BINS);
    b_eff = (base_r < 5'd2) ? 5'd2 : base_r;
  end

  assign is_rec   = (func_r == llhs_pkg::FUNC_REC);
  assign lim_prod = 69'(p_r) * 69'(r_eff);
  assign pb_prod  = 69'(p_r) * 69'(b_eff);
  assign lim_ov   = pov_r | (|lim_prod[68:64]);
  assign pb_ov    = |pb_prod[68:64];
  assign hit_rec  = lim_ov | (v_r < lim_prod[63:0]);
  assign bprod    = 69'(prev_r) * 69'(r_eff);
  assign wprod    = 69'(prev_r) * 69'(b_eff - 5'd1);
  assign bov      = prevov_r | (|bprod[68:64]);
  assign wovf     = |wprod[68:64];
  assign nxt      = off_r + 69'(width_r);
  assign addr     = llhs_pkg::ADDR_W'(k_r) * llhs_pkg::ADDR_W'(llhs_pkg::MAX_BINS)
                    + llhs_pkg::ADDR_W'(bi_r);
  assign new_sum  = rd_r[63:0] + v_r;
  assign new_cnt  = (&rd_r[95:64]) ? rd_r[95:64] : rd_r[95:64] + 32'd1;
  assign off_sat  = (|off_r[68:64]) ? '1 : off_r[63:0];
  assign beg_sum  = 65'(begin_r) + 65'(off_sat);
  assign upd_v    = in_value;

  always_comb begin
    st          = '0;
    st.in_func  = in_func;
    st.rd_oob   = (in_func == llhs_pkg::FUNC_READ) &&
                  ((6'(in_level) >= 6'(llhs_pkg::MAX_LEVELS)) || (5'(in_bin) >= r_eff));
    if (is_rec) begin
      st.lvl_hit  = hit_rec;
      st.lvl_miss = !hit_rec && (k_r == llhs_pkg::K_W'(llhs_pkg::MAX_LEVELS - 1));
      st.bin_done = wov_r || (5'(bi_r) == r_eff - 5'd1) || (69'(n_r) < nxt);
    end else begin
      st.lvl_hit  = (llhs_pkg::LVL_FW'(k_r) == rlv_r);
      st.bin_done = (llhs_pkg::BIN_FW'(bi_r) == rbi_r);
    end
    st.clr_last = (clr_idx_r == llhs_pkg::ADDR_W'(llhs_pkg::DEPTH - 1));
    st.out_busy = out_valid_r && !out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ranges_r <= llhs_pkg::RANGES_RST;
      base_r   <= llhs_pkg::BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        llhs_pkg::CFG_RANGES: ranges_r <= cfg_wdata;
        llhs_pkg::CFG_BASE:   base_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tot_r <= '0;
      min_r <= '1;
      max_r <= '0;
    end else if (cmd.load) begin
      if (in_func == llhs_pkg::FUNC_REC) begin
        cnt_r <= cnt_r + 64'd1;
        tot_r <= tot_r + upd_v;
        if (upd_v < min_r) min_r <= upd_v;
        if (upd_v > max_r) max_r <= upd_v;
      end else if (in_func == llhs_pkg::FUNC_CLEAR) begin
        cnt_r <= '0;
        tot_r <= '0;
        min_r <= '1;
        max_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r      <= in_func;
      v_r         <= in_value;
      rlv_r       <= in_level;
      rbi_r       <= in_bin;
      k_r         <= '0;
      p_r         <= 64'd1;
      pov_r       <= 1'b0;
      st_status_r <= st.rd_oob ? llhs_pkg::ST_RANGE : llhs_pkg::ST_OK;
      st_lv_r     <= (in_func == llhs_pkg::FUNC_READ) ? in_level : '0;
      st_bi_r     <= (in_func == llhs_pkg::FUNC_READ) ? in_bin : '0;
      st_sum_r    <= '0;
      st_cnt_r    <= '0;
      st_beg_r    <= '0;
    end
    if (cmd.lvl_step) begin
      if (st.lvl_miss) begin
        st_status_r <= llhs_pkg::ST_BEYOND;
      end else if (!st.lvl_hit) begin
        prev_r   <= p_r;
        prevov_r <= pov_r;
        p_r      <= pb_ov ? '1 : pb_prod[63:0];
        pov_r    <= pov_r | pb_ov;
        k_r      <= k_r + llhs_pkg::K_W'(1);
      end
    end
    if (cmd.geo) begin
      if (k_r == '0) begin
        begin_r <= '0;
        width_r <= 64'd1;
        wov_r   <= 1'b0;
      end else begin
        begin_r <= bov ? '1 : bprod[63:0];
        width_r <= (bov | wovf) ? '1 : wprod[63:0];
        wov_r   <= bov | wovf;
      end
    end
    if (cmd.diff) begin
      n_r   <= v_r - begin_r;
      bi_r  <= '0;
      off_r <= '0;
    end
    if (cmd.bin_step && !st.bin_done) begin
      bi_r  <= bi_r + llhs_pkg::BI_W'(1);
      off_r <= nxt;
    end
    if (cmd.wb) begin
      st_lv_r <= llhs_pkg::LVL_FW'(k_r);
      st_bi_r <= llhs_pkg::BIN_FW'(bi_r);
      if (is_rec) begin
        st_sum_r <= new_sum;
        st_cnt_r <= new_cnt;
        st_beg_r <= begin_r + off_r[63:0];
      end else begin
        st_sum_r <= rd_r[63:0];
        st_cnt_r <= rd_r[95:64];
        st_beg_r <= beg_sum[64] ? '1 : beg_sum[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_idx_r <= clr_idx_r + llhs_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_idx_r] <= '0;
    end else if (cmd.wb && is_rec) begin
      mem[addr] <= {new_cnt, new_sum};
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status_r <= st_status_r;
      o_lv_r     <= st_lv_r;
      o_bi_r     <= st_bi_r;
      o_sum_r    <= st_sum_r;
      o_bcnt_r   <= st_cnt_r;
      o_beg_r    <= st_beg_r;
      o_cnt_r    <= cnt_r;
      o_tot_r    <= tot_r;
      o_min_r    <= (cnt_r == '0) ? '0 : min_r;
      o_max_r    <= max_r;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_status    = o_status_r;
  assign out_level     = o_lv_r;
  assign out_bin       = o_bi_r;
  assign out_bin_sum   = o_sum_r;
  assign out_bin_count = o_bcnt_r;
  assign out_bin_begin = o_beg_r;
  assign out_count     = o_cnt_r;
  assign out_total     = o_tot_r;
  assign out_min       = o_min_r;
  assign out_max       = o_max_r;

endmodule

`default_nettype wire

// File: rtl/log_linear_histogram_stats_unit.sv
// Top level of the log-linear histogram statistics unit.
// Joins llhs_ctrl and llhs_dp; all types and codes come from llhs_pkg.
//
//   Port group | Role           | Contents
//   in_*       | stream in      | tuser: func; tdata: sample_value, read_level, read_bin
//   out_*      | stream out     | tuser: status; tdata: level..sample_max
//   cfg_*      | register write | index 0 ranges_per_level, index 1 level_base
//
// One transaction is handled at a time. A record runs level search, bin geometry, bin
// search, memory read and write-back, where the level search steps once per level L and
// the bin search once per bin B within the level. A read takes the same path, a read outside
// the table goes straight to the output, a sample beyond the top level stops after the level
// search, and a clear sweeps the 512-entry bin memory. After reset the same sweep runs first.
// in_tready rises after it. The result sits in an output register, so a stalled out_tready holds only the next result.
`default_nettype none

module log_linear_histogram_stats_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [4:0]   cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [79:0]  in_tdata,   // sample_value[63:0], read_level[68:64], read_bin[72:69]
  input  wire logic [1:0]   in_tuser,   // func
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // level_out[4:0], bin_out[8:5], bin_sum[72:9], bin_count[104:73], bin_begin[168:105],
  // sample_count[232:169], sample_total[296:233], sample_min[360:297], sample_max[424:361]
  output logic [431:0]      out_tdata,
  output logic [1:0]        out_tuser   // status
);

  llhs_pkg::cmd_t  cmd;
  llhs_pkg::stat_t st;

  logic [4:0]  level;
  logic [3:0]  bin;
  logic [63:0] bsum, bbeg, cnt, tot, mn, mx;
  logic [31:0] bcnt;

  llhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  llhs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_func       (in_tuser),
    .in_value      (in_tdata[63:0]),
    .in_level      (in_tdata[68:64]),
    .in_bin        (in_tdata[72:69]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_status    (out_tuser),
    .out_level     (level),
    .out_bin       (bin),
    .out_bin_sum   (bsum),
    .out_bin_count (bcnt),
    .out_bin_begin (bbeg),
    .out_count     (cnt),
    .out_total     (tot),
    .out_min       (mn),
    .out_max       (mx),
    .cmd           (cmd),
    .st            (st)
  );

  assign out_tdata = {7'd0, mx, mn, tot, cnt, bbeg, bcnt, bsum, bin, level};

endmodule

`default_nettype wire
